/* rtl/ket_pkg.sv */
// Shared types, constants and helpers for the keyed entry table.
// Used by the controller, the datapath and the top level. No dependencies.
package ket_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int NAME_BYTES  = 8;
  localparam int NAME_W      = 8 * NAME_BYTES;
  localparam int KEY_W       = 32;
  localparam int IN_NAME_W   = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CAP_W       = 5;
  localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_en;
    logic shift_init;
    logic shift_en;
    logic commit;
  } ket_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic do_shift;
    logic shift_done;
  } ket_sts_t;

  // Keep the low NAME_BYTES bytes up to, not including, the first zero byte.
  function automatic logic [NAME_W-1:0] clean_name(input logic [IN_NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    logic              stop;
    kept = '0;
    stop = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        kept[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

/* rtl/keyed_entry_table_unit.sv */
// Keyed entry table: top level joining controller and datapath.
// An item is loaded, scanned, for a delete of row P shifted (each later row moves one
// place down), then committed to the result registers once the output slot is free.
// One item at a time; the scan reads one entry per cycle through the table RAM port.
// Reset: entry count to zero, capacity to 16; table rows are not cleared.
module keyed_entry_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic signed [31:0]  in_key,
  input  logic signed [31:0]  in_new_key,
  input  logic [63:0]         in_name_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_found_key,
  output logic [63:0]         out_found_name,
  output logic [4:0]          out_entry_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  import ket_pkg::*;

  ket_cmd_t cmd;
  ket_sts_t sts;

  // Capacity writes are to arrive only while idle; the block does not enforce this and always takes them.
  assign cfg_ready = 1'b1;

  ket_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ket_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_new_key     (in_new_key),
    .in_name_data   (in_name_data),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_data),
    .res_status     (out_status),
    .res_found_key  (out_found_key),
    .res_found_name (out_found_name),
    .res_entry_count(out_entry_count)
  );

endmodule

/* rtl/ket_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package dependency.
module ket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ket_datapath.sv */
// Datapath of the keyed entry table: operand registers, entry RAM, scan and
// shift pipelines, result registers. Depends on ket_pkg and ket_ram.
module ket_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ket_pkg::ket_cmd_t            cmd,
  output ket_pkg::ket_sts_t            sts,
  input  logic [1:0]                   in_opcode,
  input  logic [ket_pkg::KEY_W-1:0]    in_key,
  input  logic [ket_pkg::KEY_W-1:0]    in_new_key,
  input  logic [ket_pkg::IN_NAME_W-1:0] in_name_data,
  input  logic                         cfg_we,
  input  logic [ket_pkg::CAP_W-1:0]    cfg_data,
  output logic [1:0]                   res_status,
  output logic [ket_pkg::KEY_W-1:0]    res_found_key,
  output logic [ket_pkg::IN_NAME_W-1:0] res_found_name,
  output logic [ket_pkg::CAP_W-1:0]    res_entry_count
);
  import ket_pkg::*;

  // Configuration and table occupancy.
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Operand registers for the item at work.
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r, new_key_r;
  logic [NAME_W-1:0] name_r;

  // Scan pipeline.
  logic [CNT_W-1:0]  scan_idx_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_k_r, hit_nk_r;
  logic [IDX_W-1:0]  pos_r;
  logic [NAME_W-1:0] found_nm_r;

  // Shift pipeline for delete.
  logic [CNT_W-1:0] sh_idx_r;
  logic             sh_vld_r;
  logic [IDX_W-1:0] sh_wr_addr_r;

  // Result registers.
  logic [1:0]           status_r, status_nxt;
  logic [KEY_W-1:0]     found_key_r;
  logic [IN_NAME_W-1:0] found_name_r;
  logic [CAP_W-1:0]     out_count_r;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic [LIM_W-1:0] limit;
  logic             full;
  logic             scan_issue, shift_issue;

  ket_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The effective limit is the smaller of capacity and the table depth.
  assign limit = (LIM_W'(capacity_r) < LIM_W'(TABLE_DEPTH)) ?
                 LIM_W'(capacity_r) : LIM_W'(TABLE_DEPTH);
  assign full  = (LIM_W'(count_r) >= limit);

  assign scan_issue  = cmd.scan_en && (scan_idx_r < count_r);
  assign shift_issue = cmd.shift_en && (sh_idx_r < count_r);
  assign ram_raddr   = cmd.shift_en ? sh_idx_r[IDX_W-1:0] : scan_idx_r[IDX_W-1:0];

  // Status back to the controller.
  assign sts.scan_done  = (scan_idx_r >= count_r) && !cmp_vld_r;
  assign sts.do_shift   = (op_r == OP_DELETE) && hit_k_r;
  assign sts.shift_done = (sh_idx_r >= count_r) && !sh_vld_r;

  // Result decision, table writes for the delete shift and at commit, and count update at commit.
  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    ram_we     = sh_vld_r;
    ram_waddr  = sh_wr_addr_r;
    ram_wdata  = ram_rdata;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (hit_k_r) begin
          status_nxt = ST_DUP;
        end
      end
      OP_DELETE: begin
        if (!hit_k_r) begin
          status_nxt = ST_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (!hit_k_r) begin
          status_nxt = ST_MISSING;
        end
      end
      default: begin
        if ((new_key_r != key_r) && hit_nk_r) begin
          status_nxt = ST_DUP;
        end else if (!hit_k_r) begin
          status_nxt = ST_MISSING;
        end
      end
    endcase
    if (cmd.commit && (status_nxt == ST_OK)) begin
      if (op_r == OP_INSERT) begin
        ram_we        = 1'b1;
        ram_waddr     = count_r[IDX_W-1:0];
        ram_wdata.key = key_r;
        ram_wdata.name = name_r;
        count_nxt     = count_r + CNT_W'(1);
      end else if (op_r == OP_UPDATE) begin
        ram_we        = 1'b1;
        ram_waddr     = pos_r;
        ram_wdata.key = new_key_r;
        ram_wdata.name = name_r;
      end else if (op_r == OP_DELETE) begin
        count_nxt     = count_r - CNT_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      count_r    <= '0;
      cmp_vld_r  <= 1'b0;
      sh_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_data;
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
      cmp_vld_r <= scan_issue;
      sh_vld_r  <= shift_issue;
    end
  end

  // Operand capture, scan and shift bookkeeping, result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_opcode;
      key_r      <= in_key;
      new_key_r  <= in_new_key;
      name_r     <= clean_name(in_name_data);
      scan_idx_r <= '0;
      hit_k_r    <= 1'b0;
      hit_nk_r   <= 1'b0;
    end else if (scan_issue) begin
      scan_idx_r <= scan_idx_r + CNT_W'(1);
    end
    if (scan_issue) begin
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    // Compare the entry read in the previous cycle against both keys.
    if (!cmd.load && cmp_vld_r) begin
      if (ram_rdata.key == key_r && !hit_k_r) begin
        hit_k_r    <= 1'b1;
        pos_r      <= cmp_idx_r;
        found_nm_r <= ram_rdata.name;
      end
      if (ram_rdata.key == new_key_r) begin
        hit_nk_r <= 1'b1;
      end
    end
    // Delete moves each later entry one place down.
    if (cmd.shift_init) begin
      sh_idx_r <= CNT_W'(pos_r) + CNT_W'(1);
    end else if (shift_issue) begin
      sh_idx_r     <= sh_idx_r + CNT_W'(1);
      sh_wr_addr_r <= sh_idx_r[IDX_W-1:0] - IDX_W'(1);
    end
    if (cmd.commit) begin
      status_r     <= status_nxt;
      out_count_r  <= CAP_W'(count_nxt);
      if ((op_r == OP_LOOKUP) && (status_nxt == ST_OK)) begin
        found_key_r  <= key_r;
        found_name_r <= IN_NAME_W'(found_nm_r);
      end else begin
        found_key_r  <= '0;
        found_name_r <= '0;
      end
    end
  end

  assign res_status      = status_r;
  assign res_found_key   = found_key_r;
  assign res_found_name  = found_name_r;
  assign res_entry_count = out_count_r;

  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The table is not written while a scan is reading it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_en |-> !ram_we)
    else $error("table written during scan");

  // A successful insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && op_r == OP_INSERT && status_nxt == ST_OK)
    |=> count_r == CNT_W'($past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table by one");

endmodule

/* rtl/ket_ctrl.sv */
// Controller of the keyed entry table: sequences load, scan, shift and
// commit, and owns the result valid flag. Depends on ket_pkg.
module ket_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ket_pkg::ket_cmd_t cmd,
  input  ket_pkg::ket_sts_t sts
);
  import ket_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register may be refilled once its item is taken.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Commands and next state.
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          if (sts.do_shift) begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
